### src/ltsd_pkg.sv
package ltsd_pkg;

    // Field and datapath widths.
    localparam int ITER_W = 8;
    localparam int RES_W  = 48;
    localparam int CODE_W = 24;
    localparam int THR_W  = 24;
    localparam int CFG_W  = 8;
    localparam int X_W    = 8;
    localparam int SX_W   = 16;
    localparam int SXX_W  = 24;
    localparam int SY_W   = 32;
    localparam int SXY_W  = 40;
    localparam int SCL_W  = 40;

    // APB register file geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_RESTART = 2'd1;
    localparam logic [1:0] REG_THRESH  = 2'd2;

    localparam logic [CFG_W-1:0]        WINDOW_RST  = 8'd8;
    localparam logic [CFG_W-1:0]        RESTART_RST = 8'd0;
    localparam logic signed [THR_W-1:0] THRESH_RST  = 24'sd0;

    // Log code constants: log10(2) in Q16, rounding half, and the floor code.
    localparam logic [15:0]              LOG10_2_Q16 = 16'd19728;
    localparam logic signed [SCL_W-1:0]  ROUND_HALF  = 40'sd32768;
    localparam logic signed [CODE_W-1:0] CODE_MIN    = 24'sh800000;
    localparam logic signed [7:0]        POS_BIAS    = 8'sd40;

    typedef struct packed {
        logic [CFG_W-1:0]        window_length;
        logic [CFG_W-1:0]        restart_offset;
        logic signed [THR_W-1:0] slope_threshold;
    } t_cfg;

    typedef struct packed {
        logic [SX_W-1:0]         sx;
        logic [SXX_W-1:0]        sxx;
        logic signed [SY_W-1:0]  sy;
        logic signed [SXY_W-1:0] sxy;
    } t_fit_sums;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_FIT,
        ST_CMP,
        ST_DONE
    } t_top_state;

    typedef enum logic [2:0] {
        LG_IDLE,
        LG_NORM,
        LG_FRAC,
        LG_SCALE,
        LG_DONE
    } t_log_state;

    // log2(1 + k/16) in Q16 for k = 0..16.
    function automatic logic [16:0] frac_log2(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30109;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### src/ltsd_if.sv
interface ltsd_in_if import ltsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iteration;
    logic [RES_W-1:0]  residual;

    modport source (output valid, output iteration, output residual, input ready);
    modport sink (input valid, input iteration, input residual, output ready);
endinterface

interface ltsd_out_if ();
    logic valid;
    logic ready;
    logic oscillating;

    modport source (output valid, output oscillating, input ready);
    modport sink (input valid, input oscillating, output ready);
endinterface

### src/ltsd_apb_regs.sv
module ltsd_apb_regs import ltsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length   <= WINDOW_RST;
            r_cfg.restart_offset  <= RESTART_RST;
            r_cfg.slope_threshold <= THRESH_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_WINDOW:  r_cfg.window_length   <= pwdata[CFG_W-1:0];
                REG_RESTART: r_cfg.restart_offset  <= pwdata[CFG_W-1:0];
                REG_THRESH:  r_cfg.slope_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WINDOW:  prdata = {24'd0, r_cfg.window_length};
            REG_RESTART: prdata = {24'd0, r_cfg.restart_offset};
            REG_THRESH:  prdata = {8'd0, r_cfg.slope_threshold};
            default:     prdata = '0;
        endcase
    end

endmodule

### src/ltsd_log_unit.sv
module ltsd_log_unit import ltsd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [RES_W-1:0]         i_residual,
    output logic                     o_done,
    output logic signed [CODE_W-1:0] o_code
);

    t_log_state r_state, n_state;

    logic [RES_W-1:0]         r_norm;
    logic [5:0]               r_pos;
    logic                     r_zero;
    logic signed [CODE_W-1:0] r_l2;
    logic signed [SCL_W-1:0]  r_scaled;

    logic [3:0]               seg;
    logic [11:0]              rem;
    logic [16:0]              t_lo;
    logic [16:0]              t_hi;
    logic [12:0]              diff;
    logic [24:0]              interp;
    logic [16:0]              frac;
    logic signed [7:0]        pos_off;
    logic signed [CODE_W-1:0] l2_n;

    // Mantissa bits just below the leading one, after normalization.
    assign seg     = r_norm[46:43];
    assign rem     = r_norm[42:31];
    assign t_lo    = frac_log2({1'b0, seg});
    assign t_hi    = frac_log2(5'({1'b0, seg}) + 5'd1);
    assign diff    = 13'(t_hi - t_lo);
    assign interp  = diff * rem;
    assign frac    = t_lo + 17'(interp[24:12]);
    assign pos_off = $signed({2'b00, r_pos}) - POS_BIAS;
    assign l2_n    = {pos_off, 16'h0000} + {7'd0, frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LG_IDLE: begin
                if (i_start) begin
                    n_state = LG_NORM;
                end
            end
            LG_NORM: begin
                if (r_zero) begin
                    n_state = LG_DONE;
                end else if (r_norm[RES_W-1]) begin
                    n_state = LG_FRAC;
                end
            end
            LG_FRAC:  n_state = LG_SCALE;
            LG_SCALE: n_state = LG_DONE;
            LG_DONE:  n_state = LG_IDLE;
            default:  n_state = LG_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            LG_DONE: o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    assign o_code = r_zero ? CODE_MIN : r_scaled[SCL_W-1:16];

    // Normalize eight bits a step while the top byte is empty, then one bit.
    always_ff @(posedge i_clk) begin
        if (r_state == LG_IDLE && i_start) begin
            r_norm <= i_residual;
            r_pos  <= 6'd47;
            r_zero <= (i_residual == '0);
        end else if (r_state == LG_NORM && !r_zero && !r_norm[RES_W-1]) begin
            if (r_norm[RES_W-1 -: 8] == 8'd0) begin
                r_norm <= {r_norm[RES_W-9:0], 8'd0};
                r_pos  <= r_pos - 6'd8;
            end else begin
                r_norm <= {r_norm[RES_W-2:0], 1'b0};
                r_pos  <= r_pos - 6'd1;
            end
        end
        if (r_state == LG_FRAC) begin
            r_l2 <= l2_n;
        end
        if (r_state == LG_SCALE) begin
            r_scaled <= r_l2 * $signed({1'b0, LOG10_2_Q16}) + ROUND_HALF;
        end
    end

endmodule

### src/ltsd_fit_core.sv
module ltsd_fit_core import ltsd_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic signed [CODE_W-1:0] i_wr_data,
    input  logic                     i_start,
    input  logic [X_W-1:0]           i_first,
    input  logic [X_W-1:0]           i_count,
    output logic                     o_done,
    output t_fit_sums                o_sums
);

    localparam int AW = $clog2(DEPTH);

    logic signed [CODE_W-1:0] r_mem [DEPTH];
    logic signed [CODE_W-1:0] r_rd_data;

    logic           r_rd_act;
    logic [X_W-1:0] r_rd_x;
    logic [X_W-1:0] r_rd_left;

    logic           r_v1, r_last1;
    logic [X_W-1:0] r_x1;

    logic                       r_v2, r_last2;
    logic [X_W-1:0]             r_px;
    logic [2*X_W-1:0]           r_pxx;
    logic signed [CODE_W-1:0]   r_py;
    logic signed [CODE_W+8:0]   r_pxy;

    logic      r_done;
    t_fit_sums r_sums;

    assign o_done = r_done;
    assign o_sums = r_sums;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (r_rd_act) begin
            r_rd_data <= r_mem[AW'(r_rd_x)];
        end
    end

    // Read sweep and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_start) begin
                r_rd_act <= 1'b1;
            end else if (r_rd_act && r_rd_left == 8'd1) begin
                r_rd_act <= 1'b0;
            end
            r_v1   <= r_rd_act;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd_x    <= i_first;
            r_rd_left <= i_count;
        end else if (r_rd_act) begin
            r_rd_x    <= r_rd_x + 8'd1;
            r_rd_left <= r_rd_left - 8'd1;
        end
        r_x1    <= r_rd_x;
        r_last1 <= (r_rd_left == 8'd1);

        r_px    <= r_x1;
        r_pxx   <= r_x1 * r_x1;
        r_py    <= r_rd_data;
        r_pxy   <= $signed({1'b0, r_x1}) * r_rd_data;
        r_last2 <= r_last1;

        if (i_start) begin
            r_sums <= '0;
        end else if (r_v2) begin
            r_sums.sx  <= r_sums.sx + SX_W'(r_px);
            r_sums.sxx <= r_sums.sxx + SXX_W'(r_pxx);
            r_sums.sy  <= r_sums.sy + SY_W'(r_py);
            r_sums.sxy <= r_sums.sxy + SXY_W'(r_pxy);
        end
    end

endmodule

### src/ltsd_slope_cmp.sv
module ltsd_slope_cmp import ltsd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [X_W-1:0]          i_n,
    input  t_fit_sums               i_sums,
    input  logic signed [THR_W-1:0] i_thr,
    output logic                    o_done,
    output logic                    o_flag
);

    logic [3:0] r_stg;

    logic signed [48:0] r_a;
    logic signed [48:0] r_b;
    logic [31:0]        r_c;
    logic [31:0]        r_d;
    logic signed [49:0] r_num;
    logic signed [32:0] r_den;
    logic               r_den_zero;
    logic signed [56:0] r_prod;
    logic signed [49:0] r_num2;
    logic               r_zero2;
    logic               r_flag;

    assign o_done = r_stg[3];
    assign o_flag = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[2:0], i_start};
        end
    end

    // numerator > threshold * denominator, false for a zero denominator.
    always_ff @(posedge i_clk) begin
        r_a <= $signed({1'b0, i_n}) * $signed(i_sums.sxy);
        r_b <= $signed({1'b0, i_sums.sx}) * $signed(i_sums.sy);
        r_c <= i_n * i_sums.sxx;
        r_d <= i_sums.sx * i_sums.sx;

        r_num      <= 50'(r_a) - 50'(r_b);
        r_den      <= $signed({1'b0, r_c}) - $signed({1'b0, r_d});
        r_den_zero <= (r_c == r_d);

        r_prod  <= i_thr * r_den;
        r_num2  <= r_num;
        r_zero2 <= r_den_zero;

        r_flag <= !r_zero2 && (57'(r_num2) > r_prod);
    end

endmodule

### src/log_trend_slope_detector.sv
// From acceptance to a valid result: an iteration outside the history goes straight to the
// result stage; any other passes the log normalizer, which moves a byte or a bit per cycle,
// and with a fit the block then reads one history entry per cycle and runs the pipelined
// slope compare. The block takes one item at a time; the next item can be accepted in the
// cycle after the result moves to the output register.
// Reset (synchronous, active low) clears control state and restores register defaults;
// the history memory is not cleared and holds garbage until each slot is written.
module log_trend_slope_detector import ltsd_pkg::*; #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ltsd_in_if.sink           i_item,
    ltsd_out_if.source        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int HIST_AW = $clog2(HISTORY_DEPTH);

    t_top_state r_state, n_state;
    t_cfg       cfg;

    logic [ITER_W-1:0] r_iter;
    logic              r_flag;
    logic              r_out_valid;
    logic              r_out_osc;

    // Control strobes from the state machine.
    logic item_ready;
    logic accept;
    logic iter_ok;
    logic log_start;
    logic fit_start;
    logic cmp_start;
    logic out_load;
    logic skip_fit;

    logic                     log_done;
    logic signed [CODE_W-1:0] log_code;
    logic                     fit_done;
    t_fit_sums                fit_sums;
    logic                     cmp_done;
    logic                     cmp_flag;

    logic [ITER_W:0]     need_iter;
    logic [HIST_AW-1:0]  wr_addr;
    logic [X_W-1:0]      fit_first;

    ltsd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The log unit latches the residual at start; the iteration stays in r_iter.
    ltsd_log_unit u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (log_start),
        .i_residual (i_item.residual),
        .o_done     (log_done),
        .o_code     (log_code)
    );

    // The new code is written on the cycle the log unit finishes. The fit starts on
    // that same edge and issues its first read in the next cycle, so the freshly
    // written slot is always seen without any forwarding path.
    ltsd_fit_core #(
        .DEPTH (HISTORY_DEPTH)
    ) u_fit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (log_done),
        .i_wr_addr (wr_addr),
        .i_wr_data (log_code),
        .i_start   (fit_start),
        .i_first   (fit_first),
        .i_count   (cfg.window_length),
        .o_done    (fit_done),
        .o_sums    (fit_sums)
    );

    ltsd_slope_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmp_start),
        .i_n     (cfg.window_length),
        .i_sums  (fit_sums),
        .i_thr   (cfg.slope_threshold),
        .o_done  (cmp_done),
        .o_flag  (cmp_flag)
    );

    assign accept  = i_item.valid && item_ready;
    assign iter_ok = (i_item.iteration != '0) &&
                     (11'(i_item.iteration) <= 11'(HISTORY_DEPTH));

    assign wr_addr   = HIST_AW'(r_iter - 8'd1);
    assign fit_first = r_iter - cfg.window_length;
    assign need_iter = {1'b0, cfg.window_length} + {1'b0, cfg.restart_offset};

    // No fit when detection is off (threshold not negative), when too few
    // iterations have passed, or when the window has fewer than two entries
    // (the denominator of the slope is then zero).
    assign skip_fit = !cfg.slope_threshold[THR_W-1] ||
                      ({1'b0, r_iter} < need_iter) ||
                      (cfg.window_length < 8'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = iter_ok ? ST_LOG : ST_DONE;
                end
            end
            ST_LOG: begin
                if (log_done) begin
                    n_state = skip_fit ? ST_DONE : ST_FIT;
                end
            end
            ST_FIT: begin
                if (fit_done) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (cmp_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        item_ready = 1'b0;
        log_start  = 1'b0;
        fit_start  = 1'b0;
        cmp_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                item_ready = 1'b1;
                log_start  = i_item.valid && iter_ok;
            end
            ST_LOG: begin
                fit_start = log_done && !skip_fit;
            end
            ST_FIT: begin
                cmp_start = fit_done;
            end
            ST_CMP: ;
            ST_DONE: begin
                out_load = !r_out_valid || o_result.ready;
            end
            default: ;
        endcase
    end

    // Per-item context: the iteration number and the pending flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_iter <= i_item.iteration;
            r_flag <= 1'b0;
        end else if (r_state == ST_CMP && cmp_done) begin
            r_flag <= cmp_flag;
        end
    end

    // Output register: a finished result waits here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_osc <= r_flag;
        end
    end

    assign i_item.ready         = item_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.oscillating = r_out_osc;

endmodule

### bench/log_trend_slope_detector_tb.sv
`timescale 1ns / 1ps

module log_trend_slope_detector_tb;
    import ltsd_pkg::*;

    localparam int DEPTH        = 128;
    localparam int REG_SPARE    = 3;      // unmapped register index, writes must be dropped
    localparam int LOG10_OF_2   = 19728;  // log10(2) in Q16
    localparam int FLOOR_CODE   = -8388608;
    localparam int HOLD_AT      = 260;    // accepted item count that starts the long hold-off
    localparam int HOLD_LEN     = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_SETTLE = 8;
    localparam int TAIL_CYCLES  = 200;

    typedef struct packed {
        logic [ITER_W-1:0] iteration;
        logic [RES_W-1:0]  residual;
    } t_solver_step;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Every block input is held in a local variable with a known start value.
    logic              drv_valid = 1'b0;
    logic [ITER_W-1:0] drv_iter  = '0;
    logic [RES_W-1:0]  drv_res   = '0;
    logic              res_ready = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ltsd_in_if  item_if ();
    ltsd_out_if result_if ();

    assign item_if.valid     = drv_valid;
    assign item_if.iteration = drv_iter;
    assign item_if.residual  = drv_res;
    assign result_if.ready   = res_ready;

    log_trend_slope_detector #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the register file. It only changes while the block is idle, so the
    // generator and the predictor can both read it without caring about timing.
    int wl_reg  = 8;
    int ro_reg  = 0;
    int thr_reg = 0;

    // Predictor state: the log history as the block should hold it.
    logic signed [CODE_W-1:0] log_hist [DEPTH];
    int unsigned frac_tab [0:16] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
                                     38336, 42196, 45904, 49472, 52911, 56229, 59434,
                                     62534, 65536};

    // Generator state. slot_written tracks which history slots hold a real value,
    // since a fit must never read a slot that was never written after reset.
    bit           slot_written [DEPTH];
    t_solver_step solver_steps [$];
    t_solver_step next_step;
    logic         osc_expected [$];
    logic         want_osc;
    int           items_queued = 0;
    int           items_taken  = 0;
    int           mismatch_cnt = 0;
    int           run_next     = DEPTH + 1;
    int           trend        = 20;
    bit           swept        = 1'b0;

    int  cycle_cnt    = 0;
    int  stall_cycles = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    wire calm         = (cycle_cnt % 6000) < 1500;

    // log10 of a Q40 residual as a Q7.16 code: the leading-one position gives the
    // integer part of log2, the next 16 bits index and interpolate the fraction table,
    // and the result is scaled by log10(2) with round-half and a floor shift.
    function automatic logic signed [CODE_W-1:0] log10_code_of(input logic [RES_W-1:0] r);
        int          lead;
        logic [63:0] aligned;
        int unsigned k, rem, f;
        longint      l2, scaled;
        if (r == '0) begin
            return CODE_W'(FLOOR_CODE);
        end
        lead = 0;
        for (int b = 0; b < RES_W; b++) begin
            if (r[b]) begin
                lead = b;
            end
        end
        // Bits just below the leading one, left aligned into 16 bits.
        aligned = {r, 16'b0} >> lead;
        k   = aligned[15:12];
        rem = aligned[11:0];
        f   = frac_tab[k] + (((frac_tab[k + 1] - frac_tab[k]) * rem) >> 12);
        l2  = longint'(lead - 40) * 65536 + longint'(f);
        scaled = l2 * LOG10_OF_2 + 32768;
        return CODE_W'(scaled >>> 16);
    endfunction

    // Stores the new log code and fits the slope over the latest window entries.
    // The slope test is num > threshold * den, with den == 0 never flagging.
    function automatic logic predict_oscillation(input logic [ITER_W-1:0] it,
                                                 input logic [RES_W-1:0]  r);
        longint n, sx, sy, sxy, sxx, num, den;
        if (it == 0 || int'(it) > DEPTH) begin
            return 1'b0;
        end
        log_hist[it - 1] = log10_code_of(r);
        if (thr_reg >= 0 || int'(it) < wl_reg + ro_reg) begin
            return 1'b0;
        end
        n   = wl_reg;
        sx  = 0;
        sy  = 0;
        sxy = 0;
        sxx = 0;
        for (int i = int'(it) - wl_reg; i < int'(it); i++) begin
            sx  += i;
            sy  += longint'(log_hist[i]);
            sxy += longint'(i) * longint'(log_hist[i]);
            sxx += longint'(i) * i;
        end
        num = n * sxy - sx * sy;
        den = n * sxx - sx * sx;
        if (den == 0) begin
            return 1'b0;
        end
        return num > longint'(thr_reg) * den;
    endfunction

    // A fit reads slots it-wl .. it-1; the last one is written by the item itself.
    function automatic bit fit_is_safe(input int it);
        if (it == 0 || it > DEPTH || thr_reg >= 0 || it < wl_reg + ro_reg) begin
            return 1'b1;
        end
        for (int i = it - wl_reg; i < it - 1; i++) begin
            if (!slot_written[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [RES_W-1:0] rand_residual();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return RES_W'(w) >> $urandom_range(47);
        endcase
    endfunction

    // Residual of a solver run: the leading one follows a random walk, so the log
    // history both rises and falls and the fitted slope takes either sign.
    function automatic logic [RES_W-1:0] run_residual(input int lvl);
        logic [RES_W-1:0] v;
        v = RES_W'({$urandom, $urandom});
        v[RES_W-1] = 1'b1;
        if ($urandom_range(19) == 0) begin
            return '0;
        end
        return v >> (RES_W - 1 - lvl);
    endfunction

    task automatic queue_step(input int it, input logic [RES_W-1:0] r);
        solver_steps.push_back('{iteration: ITER_W'(it), residual: r});
        if (it >= 1 && it <= DEPTH) begin
            slot_written[it - 1] = 1'b1;
        end
        items_queued++;
    endtask

    // Mostly well-formed solver runs (consecutive iterations from one, or from a
    // random start once every slot holds data), mixed with stray iteration numbers,
    // including zero and values past the history depth.
    task automatic gen_phase(input int count);
        int               made;
        int               it;
        logic [RES_W-1:0] r;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 20) begin
                it = $urandom_range(255);
                r  = rand_residual();
            end else begin
                if (run_next > DEPTH || (swept && $urandom_range(99) < 3)) begin
                    run_next = (swept && $urandom_range(3) == 0) ? $urandom_range(DEPTH, 1) : 1;
                    trend    = $urandom_range(47);
                end
                it = run_next;
                run_next++;
                if (it == DEPTH) begin
                    swept = 1'b1;
                end
                trend = trend + int'($urandom_range(4)) - 2;
                if (trend < 0) begin
                    trend = 0;
                end else if (trend > RES_W - 1) begin
                    trend = RES_W - 1;
                end
                r = run_residual(trend);
            end
            if (fit_is_safe(it)) begin
                queue_step(it, r);
                if (it >= 1 && it <= DEPTH) begin
                    made++;
                end
            end
        end
    endtask

    // Register write with a setup and an access phase; the write lands on the access-phase edge.
    task automatic apb_write(input int idx, input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WINDOW:  wl_reg  = value & 8'hFF;
            REG_RESTART: ro_reg  = value & 8'hFF;
            REG_THRESH:  thr_reg = {{8{value[23]}}, value[23:0]};
            default:     ;
        endcase
    endtask

    // Idle means every queued item was taken and every expected result came back.
    task automatic wait_drained(input int settle);
        while (items_taken != items_queued || osc_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic run_phase(input int wl, input int ro, input int thr, input int count);
        wait_drained(PHASE_SETTLE);
        apb_write(REG_WINDOW, wl);
        apb_write(REG_RESTART, ro);
        apb_write(REG_THRESH, thr);
        gen_phase(count);
    endtask

    task automatic note_mismatch(input logic want, input logic got, input bit orphan);
        if (mismatch_cnt < 10) begin
            if (orphan) begin
                $display("result with no item outstanding: oscillating=%0d", got);
            end else begin
                $display("oscillating mismatch: expected %0d, got %0d", want, got);
            end
        end
        mismatch_cnt++;
    endtask

    // Item driver: keeps offering while items are pending, with random gaps except
    // during the calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || item_if.ready) begin
            if (solver_steps.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                next_step = solver_steps.pop_front();
                drv_valid <= 1'b1;
                drv_iter  <= next_step.iteration;
                drv_res   <= next_step.residual;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off once enough items went in; with the sender still
    // offering, the block fills up and has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_taken == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 12);
        end
    end

    // Monitor: the result check runs before the new expectation is queued, so a
    // result and an item taken on the same edge can never be paired by mistake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (osc_expected.size() == 0) begin
                    note_mismatch(1'b0, result_if.oscillating, 1'b1);
                end else begin
                    want_osc = osc_expected.pop_front();
                    if (result_if.oscillating !== want_osc) begin
                        note_mismatch(want_osc, result_if.oscillating, 1'b0);
                    end
                end
            end
            if (item_if.valid && item_if.ready) begin
                osc_expected.push_back(predict_oscillation(item_if.iteration,
                                                           item_if.residual));
                items_taken <= items_taken + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, detection off: out-of-range iterations, a zero residual,
        // the largest residual, one LSB, exactly one, and the top bit alone.
        queue_step(0, 48'hFFFF_FFFF_FFFF);
        queue_step(200, 48'd5);
        queue_step(129, 48'd0);
        queue_step(1, 48'd0);
        queue_step(2, 48'hFFFF_FFFF_FFFF);
        queue_step(3, 48'd1);
        queue_step(4, 48'h010000000000);
        queue_step(5, 48'h800000000000);
        queue_step(6, 48'h8000_0000_0001);
        queue_step(DEPTH, 48'h0000_0012_3456);

        // Two-entry window with the smallest negative threshold: too few iterations,
        // a rising pair, falling pairs down to the floor code, then a rise again.
        run_phase(2, 0, -1, 0);
        queue_step(1, 48'h0000_4000_0000);
        queue_step(2, 48'h0000_8000_0000);
        queue_step(3, 48'h0000_0010_0000);
        queue_step(4, 48'd0);
        queue_step(5, 48'hFFFF_FFFF_FFFF);

        // One-entry window with a restart offset and the most negative threshold:
        // the denominator is zero, and one item falls short of the offset.
        run_phase(1, 3, -8388608, 0);
        queue_step(4, 48'd1);
        queue_step(3, 48'd5);

        // Empty window, plus a write to the unmapped register that must be dropped.
        run_phase(0, 0, -65536, 0);
        apb_write(REG_SPARE, 32'h0000_0055);
        queue_step(6, 48'd7);

        // Random part. The first phase sweeps the whole history once, after which
        // runs may start anywhere. The threshold settings reach both ends of its range.
        run_phase(8, 0, -6554, 160);
        run_phase(128, 0, -1, 55);
        run_phase(128, 128, -100000, 50);
        run_phase(0, 0, -8388608, 55);
        run_phase(16, 5, -300000, 55);
        run_phase(4, 128, 8388607, 50);
        run_phase(3, 0, -20000, 55);

        wait_drained(TAIL_CYCLES);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
src/ltsd_pkg.sv
src/ltsd_if.sv
src/ltsd_apb_regs.sv
src/ltsd_log_unit.sv
src/ltsd_fit_core.sv
src/ltsd_slope_cmp.sv
src/log_trend_slope_detector.sv
bench/log_trend_slope_detector_tb.sv
